// ===== hdl/aic_pkg.sv =====
// Shared widths, codes and reset values for the adjacency to incidence converter.
package aic_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned VTX_W  = 6;
  localparam int unsigned EDGE_W = 9;

  localparam logic [VTX_W-1:0] VCOUNT_RESET = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

endpackage

// ===== hdl/aic_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module aic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/adjacency_to_incidence_matrix.sv =====
// Top level: adjacency store, edge list build and incidence cell reads.
//
//  channel  direction  handshake                  payload
//  cfg      in         cfg_valid_i / cfg_ready_o  cfg_vertex_count_i
//  in       in         in_valid_i / in_stall_o    op_i vertex_i neighbour_i edge_number_i
//  out      out        out_valid_o / out_stall_i  edge_total_o cell_bit_o status_o
//
// One request at a time. Valid reads pass through S_RD, and clear, flagged requests and builds
// over fewer than two vertices through S_RESP; an add does a read-modify-write of both adjacency rows.
// A build reads each scanned row (vertex count less one) and writes its edges one at a time, bound
// by the registered row read and the single write port of the edge memory.
// Reset clears the adjacency row valid flags at once; no clearing pass is needed.
// A result waits in the output register while out_stall_i is high.
module adjacency_to_incidence_matrix #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned EDGE_DEPTH   = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [aic_pkg::VTX_W-1:0]   cfg_vertex_count_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [aic_pkg::OP_W-1:0]    op_i,
  input  logic [aic_pkg::VTX_W-1:0]   vertex_i,
  input  logic [aic_pkg::VTX_W-1:0]   neighbour_i,
  input  logic [aic_pkg::EDGE_W-1:0]  edge_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [aic_pkg::EDGE_W-1:0]  edge_total_o,
  output logic                        cell_bit_o,
  output logic                        status_o
);

  import aic_pkg::*;

  localparam int unsigned RIW      = $clog2(MAX_VERTICES);
  localparam int unsigned EAW      = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int unsigned EP_W     = 2 * RIW;
  localparam int unsigned EDGE_CAP = (EDGE_DEPTH < 511) ? EDGE_DEPTH : 511;
  localparam int unsigned NW       = VTX_W + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ADD1 = 8'b0000_0010,
    S_ADD2 = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_BLD  = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_RESP = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [VTX_W-1:0]        vcount_q;
  logic [NW-1:0]           n_vert;
  logic [MAX_VERTICES-1:0] row_vld_q, row_vld_d;
  logic                    adj_rvld_q;
  logic [RIW-1:0]          vm1_q, vm1_d, wm1_q, wm1_d, i_q, i_d;
  logic [MAX_VERTICES-1:0] mask_q, mask_d;
  logic [EDGE_W-1:0]       edge_counter_q, edge_counter_d;
  logic                    pend_cell_q, pend_cell_d, pend_status_q, pend_status_d;
  logic                    out_valid_q, out_valid_d;
  logic [EDGE_W-1:0]       out_total_q, out_total_d;
  logic                    out_cell_q, out_cell_d, out_status_q, out_status_d;

  logic                    in_acc, out_free;
  logic                    v_ok, w_ok, e_ok;
  logic [RIW-1:0]          v_m1_in, w_m1_in;
  logic                    adj_we, adj_re;
  logic [RIW-1:0]          adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, adj_row, v_bit, w_bit;
  logic [MAX_VERTICES-1:0] col_mask, low_bit;
  logic [RIW-1:0]          low_idx;
  logic                    edge_we, edge_re;
  logic [EAW-1:0]          edge_waddr, edge_raddr;
  logic [EP_W-1:0]         edge_wdata, edge_rdata;
  logic                    last_row, cap_hit;
  logic                    fin, fin_cell, fin_status;

  aic_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  aic_ram #(
    .WIDTH (EP_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if ({1'b0, vcount_q} > NW'(MAX_VERTICES)) begin
      n_vert = NW'(MAX_VERTICES);
    end else begin
      n_vert = {1'b0, vcount_q};
    end
  end

  assign v_ok    = (vertex_i != '0) && ({1'b0, vertex_i} <= n_vert);
  assign w_ok    = (neighbour_i != '0) && ({1'b0, neighbour_i} <= n_vert);
  assign e_ok    = (edge_number_i != '0) && (edge_number_i <= edge_counter_q);
  assign v_m1_in = RIW'(vertex_i - VTX_W'(1));
  assign w_m1_in = RIW'(neighbour_i - VTX_W'(1));

  // rows never written since reset or clear read as zero
  assign adj_row = adj_rvld_q ? adj_rdata : '0;
  assign v_bit   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << vm1_q;
  assign w_bit   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wm1_q;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      col_mask[j] = (j > int'(i_q)) && (j < int'(n_vert));
    end
  end

  assign low_bit = mask_q & (~mask_q + MAX_VERTICES'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (low_bit[j]) begin
        low_idx = low_idx | RIW'(j);
      end
    end
  end

  assign last_row   = (NW'(i_q) + NW'(2)) == n_vert;
  assign cap_hit    = (edge_counter_q == EDGE_W'(EDGE_CAP));
  assign edge_waddr = EAW'(edge_counter_q);
  assign edge_wdata = {i_q, low_idx};
  assign edge_raddr = EAW'(edge_number_i - EDGE_W'(1));

  always_comb begin
    state_d        = state_q;
    vm1_d          = vm1_q;
    wm1_d          = wm1_q;
    i_d            = i_q;
    mask_d         = mask_q;
    edge_counter_d = edge_counter_q;
    pend_cell_d    = pend_cell_q;
    pend_status_d  = pend_status_q;
    row_vld_d      = row_vld_q;
    adj_re         = 1'b0;
    adj_raddr      = v_m1_in;
    adj_we         = 1'b0;
    adj_waddr      = vm1_q;
    adj_wdata      = adj_row | w_bit;
    edge_re        = 1'b0;
    edge_we        = 1'b0;
    fin            = 1'b0;
    fin_cell       = 1'b0;
    fin_status     = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    out_total_d    = out_total_q;
    out_cell_d     = out_cell_q;
    out_status_d   = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          vm1_d         = v_m1_in;
          wm1_d         = w_m1_in;
          pend_cell_d   = 1'b0;
          pend_status_d = 1'b0;
          case (op_e'(op_i))
            OP_ADD: begin
              if (v_ok && w_ok) begin
                adj_re  = 1'b1;
                state_d = S_ADD1;
              end else begin
                pend_status_d = 1'b1;
                state_d       = S_RESP;
              end
            end
            OP_BUILD: begin
              edge_counter_d = '0;
              i_d            = '0;
              if (n_vert >= NW'(2)) begin
                adj_re    = 1'b1;
                adj_raddr = '0;
                state_d   = S_BLD;
              end else begin
                state_d = S_RESP;
              end
            end
            OP_READ: begin
              if (v_ok && e_ok) begin
                edge_re = 1'b1;
                state_d = S_RD;
              end else begin
                pend_status_d = 1'b1;
                state_d       = S_RESP;
              end
            end
            OP_CLEAR: begin
              row_vld_d      = '0;
              edge_counter_d = '0;
              state_d        = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ADD1: begin
        // write row v, fetch row w; a self pair rewrites the same bit
        adj_we           = 1'b1;
        adj_waddr        = vm1_q;
        adj_wdata        = adj_row | w_bit;
        row_vld_d[vm1_q] = 1'b1;
        adj_re           = 1'b1;
        adj_raddr        = wm1_q;
        state_d          = S_ADD2;
      end
      S_ADD2: begin
        adj_we           = 1'b1;
        adj_waddr        = wm1_q;
        adj_wdata        = adj_row | v_bit;
        row_vld_d[wm1_q] = 1'b1;
        fin              = 1'b1;
      end
      S_RD: begin
        fin      = 1'b1;
        fin_cell = (edge_rdata[EP_W-1:RIW] == vm1_q) || (edge_rdata[RIW-1:0] == vm1_q);
      end
      S_BLD: begin
        mask_d  = adj_row & col_mask;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if ((mask_q != '0) && !cap_hit) begin
          edge_we        = 1'b1;
          edge_counter_d = edge_counter_q + EDGE_W'(1);
          mask_d         = mask_q & ~low_bit;
        end else if (cap_hit || last_row) begin
          fin = 1'b1;
        end else begin
          i_d       = i_q + RIW'(1);
          adj_re    = 1'b1;
          adj_raddr = i_q + RIW'(1);
          state_d   = S_BLD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_total_d  = edge_counter_q;
          out_cell_d   = pend_cell_q;
          out_status_d = pend_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_total_d  = edge_counter_q;
        out_cell_d   = fin_cell;
        out_status_d = fin_status;
        state_d      = S_IDLE;
      end else begin
        pend_cell_d   = fin_cell;
        pend_status_d = fin_status;
        state_d       = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      vcount_q       <= VCOUNT_RESET;
      row_vld_q      <= '0;
      edge_counter_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      row_vld_q      <= row_vld_d;
      edge_counter_q <= edge_counter_d;
      out_valid_q    <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_vertex_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vm1_q         <= vm1_d;
    wm1_q         <= wm1_d;
    i_q           <= i_d;
    mask_q        <= mask_d;
    pend_cell_q   <= pend_cell_d;
    pend_status_q <= pend_status_d;
    out_total_q   <= out_total_d;
    out_cell_q    <= out_cell_d;
    out_status_q  <= out_status_d;
    if (adj_re) begin
      adj_rvld_q <= row_vld_q[adj_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_total_o = out_total_q;
  assign cell_bit_o   = out_cell_q;
  assign status_o     = out_status_q;

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("request accepted but block returned to idle at once");

  a_edge_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_we |-> ((state_q == S_SCAN) && !cap_hit))
    else $error("edge write outside scan or beyond capacity");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_total_o <= EDGE_W'(EDGE_CAP)))
    else $error("edge total above capacity");

  a_cell_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cell_bit_o && status_o))
    else $error("flagged result carries a cell bit");

endmodule

// ===== sim/adjacency_to_incidence_matrix_tb.sv =====
// Self-checking bench for the adjacency to incidence converter, with a built-in graph predictor.
module adjacency_to_incidence_matrix_tb;
  import aic_pkg::*;

  localparam int unsigned MAX_V       = 32;
  localparam int unsigned EDGE_DEPTH  = 512;
  localparam int unsigned EDGE_CAP    = (EDGE_DEPTH < 511) ? EDGE_DEPTH : 511;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 800000;

  typedef struct packed {
    op_e               op;
    logic [VTX_W-1:0]  vertex;
    logic [VTX_W-1:0]  neighbour;
    logic [EDGE_W-1:0] edge_no;
  } request_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_total;
    logic              cell_bit;
    logic              status;
  } answer_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [VTX_W-1:0]    cfg_vertex_count_i = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i               = '0;
  logic [VTX_W-1:0]    vertex_i           = '0;
  logic [VTX_W-1:0]    neighbour_i        = '0;
  logic [EDGE_W-1:0]   edge_number_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [EDGE_W-1:0]   edge_total_o;
  logic                cell_bit_o;
  logic                status_o;

  // predictor state
  logic [VTX_W-1:0]    vertex_limit = VCOUNT_RESET;
  logic [MAX_V-1:0]    adj_rows [MAX_V];
  logic [VTX_W-1:0]    end_lo [EDGE_DEPTH];
  logic [VTX_W-1:0]    end_hi [EDGE_DEPTH];
  logic [EDGE_W-1:0]   edge_count = '0;

  request_t            requests_waiting [$];
  answer_t             answers_due [$];
  int unsigned         issued_count   = 0;
  int unsigned         accepted_count = 0;
  int unsigned         answered_count = 0;
  int unsigned         mismatches     = 0;
  int unsigned         builds_run     = 0;
  int unsigned         hits_seen      = 0;
  int unsigned         flagged_seen   = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         hold_requests  = 0;
  int unsigned         holds_served   = 0;
  int unsigned         send_wait      = 0;
  int unsigned         recv_wait      = 0;
  bit                  send_idle_on   = 1'b1;
  bit                  recv_idle_on   = 1'b1;
  logic                out_hold       = 1'b0;

  adjacency_to_incidence_matrix #(
    .MAX_VERTICES(MAX_V),
    .EDGE_DEPTH  (EDGE_DEPTH)
  ) DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    for (int r = 0; r < MAX_V; r++) adj_rows[r] = '0;
  end

  function automatic answer_t incidence_answer(input op_e op, input logic [VTX_W-1:0] v,
                                               input logic [VTX_W-1:0] w,
                                               input logic [EDGE_W-1:0] e);
    answer_t     ans;
    int unsigned n, i, j, cnt, idx;
    bit          v_ok;
    n    = (vertex_limit > MAX_V) ? MAX_V : vertex_limit;
    ans  = '0;
    v_ok = (v >= 1) && (v <= n);
    case (op)
      OP_ADD: begin
        if (v_ok && w >= 1 && w <= n) begin
          adj_rows[v-1][w-1] = 1'b1;
          adj_rows[w-1][v-1] = 1'b1;
        end else begin
          ans.status = 1'b1;
        end
      end
      OP_BUILD: begin
        cnt = 0;
        for (i = 1; i <= n; i++) begin
          for (j = i + 1; j <= n; j++) begin
            if (adj_rows[i-1][j-1] && cnt < EDGE_CAP) begin
              end_lo[cnt] = VTX_W'(i);
              end_hi[cnt] = VTX_W'(j);
              cnt++;
            end
          end
        end
        edge_count = EDGE_W'(cnt);
        builds_run++;
      end
      OP_READ: begin
        if (v_ok && e >= 1 && e <= edge_count) begin
          idx = (e - 1) % EDGE_DEPTH;
          ans.cell_bit = (end_lo[idx] == v) || (end_hi[idx] == v);
        end else begin
          ans.status = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < MAX_V; i++) adj_rows[i] = '0;
        edge_count = '0;
      end
    endcase
    ans.edge_total = edge_count;
    if (ans.status) flagged_seen++;
    if (ans.cell_bit) hits_seen++;
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [EDGE_W-1:0] want,
                             input logic [EDGE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        answers_due.insert(answers_due.size(),
                           incidence_answer(op_e'(op_i), vertex_i, neighbour_i,
                                            edge_number_i));
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (requests_waiting.size() != 0) begin
          next_req = requests_waiting.pop_front();
          op_i          <= next_req.op;
          vertex_i      <= next_req.vertex;
          neighbour_i   <= next_req.neighbour;
          edge_number_i <= next_req.edge_no;
          in_valid_i    <= 1'b1;
          if (send_idle_on && $urandom_range(0, 1) != 0) send_wait = $urandom_range(0, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, edge_total %0d cell_bit %0d status %0d",
                   $time, edge_total_o, cell_bit_o, status_o);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          answered_count++;
          check_field("edge_total", want.edge_total, edge_total_o);
          check_field("cell_bit", EDGE_W'(want.cell_bit), EDGE_W'(cell_bit_o));
          check_field("status", EDGE_W'(want.status), EDGE_W'(status_o));
        end
        recv_wait = (recv_idle_on && $urandom_range(0, 1) != 0) ? $urandom_range(0, 11) : 0;
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall_i <= out_hold || (recv_wait != 0);
    end
  end

  // long receiver hold-off, sender keeps offering
  always begin
    wait (hold_requests != holds_served);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
    holds_served++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still pending", $time, answers_due.size());
    $display("adjacency_to_incidence_matrix_tb: FAIL");
    $finish;
  end

  task automatic push_request(input op_e op, input int unsigned v, input int unsigned w,
                              input int unsigned e);
    requests_waiting.insert(requests_waiting.size(),
                            '{op: op, vertex: VTX_W'(v), neighbour: VTX_W'(w),
                              edge_no: EDGE_W'(e)});
    issued_count++;
  endtask

  task automatic wait_quiet();
    wait (answered_count == issued_count);
    @(negedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VTX_W-1:0] value);
    wait_quiet();
    @(posedge clk_i);
    cfg_vertex_count_i <= value;
    cfg_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vertex_limit = value;
    @(negedge clk_i);
  endtask

  function automatic int unsigned pick_vertex(input int unsigned vmax);
    if (vmax == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(1, vmax);
  endfunction

  initial begin
    int unsigned    phase, vmax, issued_before, n_adds, n_reads, k, r, e, v;
    int unsigned    phase_counts [PHASES];
    phase_counts = '{2, 32, 1, 9, 63, 17, 3, 32, 6, 0};
    phase_counts[PHASES-1] = $urandom_range(1, 32);

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset vertex count, field extremes, flagged operands, self pair
    push_request(OP_READ, 1, 0, 1);
    push_request(OP_ADD, 1, 2, 0);
    push_request(OP_ADD, 32, 31, 511);
    push_request(OP_ADD, 5, 5, 0);
    push_request(OP_ADD, 0, 3, 0);
    push_request(OP_ADD, 4, 33, 0);
    push_request(OP_ADD, 1, 32, 0);
    push_request(OP_BUILD, 0, 0, 0);
    push_request(OP_READ, 1, 0, 1);
    push_request(OP_READ, 32, 63, 3);
    push_request(OP_READ, 3, 0, 2);
    push_request(OP_READ, 1, 0, 0);
    push_request(OP_READ, 1, 0, 4);
    push_request(OP_READ, 63, 0, 1);
    // shrink vertex count over a built edge list
    write_vertex_count(4);
    push_request(OP_READ, 32, 0, 3);
    push_request(OP_READ, 1, 0, 2);
    push_request(OP_CLEAR, 63, 63, 511);
    push_request(OP_READ, 1, 0, 1);
    // no vertex in use
    write_vertex_count(0);
    push_request(OP_ADD, 1, 2, 0);
    push_request(OP_BUILD, 0, 0, 0);
    // above the maximum, saturates
    write_vertex_count(63);
    push_request(OP_ADD, 32, 1, 0);
    push_request(OP_ADD, 33, 1, 0);
    push_request(OP_BUILD, 0, 0, 0);
    push_request(OP_READ, 32, 0, 1);
    push_request(OP_READ, 2, 0, 511);

    for (phase = 0; phase < PHASES; phase++) begin
      write_vertex_count(VTX_W'(phase_counts[phase]));
      vmax = (phase_counts[phase] > MAX_V) ? MAX_V : phase_counts[phase];
      issued_before = issued_count;
      if (phase == 1 || phase == 6) hold_requests++;
      while (issued_count - issued_before < PHASE_ITEMS) begin
        send_idle_on = $urandom_range(0, 3) != 0;
        recv_idle_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0)
          push_request(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 511));
        n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 80)
                                              : $urandom_range(1, 4 + vmax);
        for (k = 0; k < n_adds; k++) begin
          if ($urandom_range(0, 19) == 0)
            push_request(op_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 511));
          else
            push_request(OP_ADD, pick_vertex(vmax), pick_vertex(vmax), $urandom_range(0, 511));
        end
        push_request(OP_BUILD, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 511));
        // edge count of this build is known once it has been accepted
        wait (accepted_count == issued_count);
        @(negedge clk_i);
        n_reads = $urandom_range(2, 12);
        for (k = 0; k < n_reads; k++) begin
          r = $urandom_range(0, 9);
          if (edge_count == 0 || r == 0) e = $urandom_range(0, 511);
          else if (r == 1) e = ($urandom_range(0, 1) != 0) ? 0 : edge_count + 1;
          else e = $urandom_range(1, edge_count);
          if (e >= 1 && e <= edge_count && r > 4)
            v = ($urandom_range(0, 1) != 0) ? end_lo[e-1] : end_hi[e-1];
          else
            v = pick_vertex(vmax);
          push_request(OP_READ, v, $urandom_range(0, 63), e);
        end
      end
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d requests with %0d builds; %0d incidence hits, %0d flagged requests.",
             issued_count, builds_run, hits_seen, flagged_seen);
    $display("Vertex counts 0, 1, 32, 63 and a spread in between visited; %0d long hold-offs.",
             holds_served);
    if (mismatches == 0) begin
      $display("adjacency_to_incidence_matrix_tb: PASS");
    end else begin
      $display("adjacency_to_incidence_matrix_tb: FAIL");
    end
    $finish;
  end

endmodule
